// ----- rtl/core/mrr_pkg.sv -----
package mrr_pkg;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NORESP = 2'd1;
  localparam logic [1:0] ST_CRC    = 2'd2;
  localparam logic [1:0] ST_EXC    = 2'd3;

  localparam logic       KIND_DATA = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [7:0] FC_READ_COILS    = 8'h01;
  localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT    = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] TIMEOUT_INIT = 16'd1000;
  localparam logic [15:0] IDLE_MAX     = 16'hFFFF;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic [8:0] frame_length;
    logic [7:0] exception_code;
    logic [7:0] function_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic res_t make_end(input logic [8:0] cnt, input logic [15:0] crc,
                                    input logic [7:0] func, input logic [7:0] third);
    res_t r;
    r = '0;
    r.kind = KIND_END;
    r.frame_length = cnt;
    r.function_code = func;
    r.last = 1'b1;
    if (cnt == 9'd0) begin
      r.status = ST_NORESP;
    end else if (cnt < 9'd3 || crc != 16'd0) begin
      r.status = ST_CRC;
    end else if (func[7]) begin
      r.status = ST_EXC;
      r.exception_code = third;
    end else begin
      r.status = ST_OK;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mrr_if.sv -----
interface mrr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface mrr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] status;
  logic [8:0] frame_length;
  logic [7:0] exception_code;
  logic [7:0] function_code;
  logic       last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output frame_length, output exception_code,
                  output function_code, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input status, input frame_length, input exception_code,
                input function_code, input last, output ready);
endinterface

// ----- rtl/core/mrr_core.sv -----
module mrr_core import mrr_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        take,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  output push_t       push
);

  logic        busy, busy_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [7:0]  func_byte, func_byte_next;
  logic [7:0]  third_byte, third_byte_next;
  logic [15:0] timeout_ticks;

  always_comb begin
    logic [8:0]  cnt_inc;
    logic [7:0]  func_upd;
    logic [7:0]  third_upd;
    logic [15:0] crc_upd;
    logic [15:0] idle_inc;
    logic        done;
    res_t        echo;

    busy_next       = busy;
    byte_count_next = byte_count;
    crc_acc_next    = crc_acc;
    idle_ticks_next = idle_ticks;
    func_byte_next  = func_byte;
    third_byte_next = third_byte;
    push            = '0;

    cnt_inc   = byte_count + 9'd1;
    func_upd  = (byte_count == 9'd1) ? rx_byte : func_byte;
    third_upd = (byte_count == 9'd2) ? rx_byte : third_byte;
    crc_upd   = crc_fold(crc_acc, rx_byte);
    idle_inc  = (idle_ticks != IDLE_MAX) ? idle_ticks + 16'd1 : idle_ticks;

    done = 1'b0;
    if (cnt_inc >= 9'(MAX_FRAME)) begin
      done = 1'b1;
    end else if (cnt_inc >= 9'd5) begin
      if (func_upd[7]) begin
        done = 1'b1;
      end else if (func_upd inside {FC_READ_COILS, FC_READ_DISCRETE,
                                    FC_READ_HOLDING, FC_READ_INPUT}) begin
        done = {1'b0, cnt_inc} >= (10'd5 + {2'b00, third_upd});
      end else if (func_upd == FC_WRITE_SINGLE || func_upd == FC_WRITE_MULTI) begin
        done = cnt_inc >= 9'd8;
      end
    end

    echo = '0;
    echo.kind = KIND_DATA;
    echo.data_byte = rx_byte;
    echo.byte_index = byte_count[7:0];

    if (take) begin
      case (op)
        OP_START: begin
          busy_next       = 1'b1;
          byte_count_next = '0;
          crc_acc_next    = CRC_INIT;
          idle_ticks_next = '0;
          func_byte_next  = '0;
          third_byte_next = '0;
        end
        OP_BYTE: begin
          if (busy) begin
            byte_count_next = cnt_inc;
            crc_acc_next    = crc_upd;
            idle_ticks_next = '0;
            func_byte_next  = func_upd;
            third_byte_next = third_upd;
            push.r0 = echo;
            push.n  = 2'd1;
            if (done) begin
              push.r1   = make_end(cnt_inc, crc_upd, func_upd, third_upd);
              push.n    = 2'd2;
              busy_next = 1'b0;
            end
          end
        end
        OP_TICK: begin
          if (busy) begin
            idle_ticks_next = idle_inc;
            if (idle_inc >= timeout_ticks) begin
              push.r0   = make_end(byte_count, crc_acc, func_byte, third_byte);
              push.n    = 2'd1;
              busy_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      byte_count    <= '0;
      crc_acc       <= CRC_INIT;
      idle_ticks    <= '0;
      func_byte     <= '0;
      third_byte    <= '0;
      timeout_ticks <= TIMEOUT_INIT;
    end else begin
      busy       <= busy_next;
      byte_count <= byte_count_next;
      crc_acc    <= crc_acc_next;
      idle_ticks <= idle_ticks_next;
      func_byte  <= func_byte_next;
      third_byte <= third_byte_next;
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
    end
  end

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    take && op == OP_START |=> busy && byte_count == 9'd0 && crc_acc == CRC_INIT)
    else $error("start did not open a fresh frame");

  a_push_when_busy: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> busy)
    else $error("result produced outside a frame");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |=> !busy)
    else $error("frame still open after end status");

endmodule

// ----- rtl/core/mrr_res_queue.sv -----
module mrr_res_queue import mrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       space,
  mrr_out_if.source  out_ch
);

  res_t              slot [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;
  res_t              head;

  assign space = count <= QCNT_W'(QDEPTH - 2);
  assign pop   = out_ch.valid && out_ch.ready;
  assign head  = slot[rd_ptr];

  assign out_ch.valid          = count != '0;
  assign out_ch.kind           = head.kind;
  assign out_ch.data_byte      = head.data_byte;
  assign out_ch.byte_index     = head.byte_index;
  assign out_ch.status         = head.status;
  assign out_ch.frame_length   = head.frame_length;
  assign out_ch.exception_code = head.exception_code;
  assign out_ch.function_code  = head.function_code;
  assign out_ch.last           = head.last;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slot[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      slot[wr_ptr + QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> space)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/modbus_rtu_response_receiver.sv -----
// Each result is registered in the result queue and offered on out_ch behind any results queued before it.
// Throughput: one input transaction per cycle while the result queue has room for two;
//   a byte that closes a frame yields two results, drained one per cycle while out_ch.ready is high.
// Reset (rst, synchronous, active high): no frame open, result queue empty,
//   timeout_ticks back to 1000.
module modbus_rtu_response_receiver import mrr_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mrr_in_if.sink      in_ch,
  mrr_out_if.source   out_ch
);

  push_t push;
  logic  space;

  assign in_ch.ready = space;

  mrr_core #(.MAX_FRAME(MAX_FRAME)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (in_ch.valid && in_ch.ready),
    .op        (in_ch.op),
    .rx_byte   (in_ch.rx_byte),
    .push      (push)
  );

  mrr_res_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule
